/* sv/gbfr_pkg.sv */
package gbfr_pkg;

   // framing bytes
   localparam logic [7:0] SYNC_ONE   = 8'hB5;
   localparam logic [7:0] SYNC_TWO   = 8'h62;
   localparam logic [7:0] TEXT_START = 8'h24;
   localparam logic [7:0] TEXT_LF    = 8'h0A;
   localparam logic [7:0] TEXT_CR    = 8'h0D;

   // result event codes
   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_PAYLOAD   = 3'd1,
      EV_FRAME_END = 3'd2,
      EV_TEXT_CHAR = 3'd3,
      EV_LINE_END  = 3'd4,
      EV_LINE_DROP = 3'd5
   } event_type;

   // frame end status codes
   typedef enum logic [1:0] {
      ST_GOOD     = 2'd0,
      ST_CKSUM    = 2'd1,
      ST_TOO_LONG = 2'd2
   } status_type;

   // register indexes
   localparam logic [1:0] CSR_MAX_PAYLOAD   = 2'd0;
   localparam logic [1:0] CSR_NMEA_LINE_MAX = 2'd1;

   localparam logic [15:0] MAX_PAYLOAD_RST   = 16'd1024;
   localparam logic [8:0]  NMEA_LINE_MAX_RST = 9'd128;
   localparam logic [8:0]  LINE_SIZE_MIN     = 9'd2;
   localparam logic [8:0]  LINE_SIZE_MAX     = 9'd256;

endpackage

/* sv/gnss_binary_frame_receiver_core.sv */
// Channel  | Direction | Handshake             | Payload
// req_     | in        | req_valid/req_ready   | rx_byte
// rsp_     | out       | rsp_valid/rsp_ready   | event_res, data_byte, msg_class, msg_id,
//          |           |                       | frame_length, byte_offset, frame_status
// csr_     | in        | csr_we                | csr_index, csr_wdata (16 bit)
//
// Every byte gives exactly one result item in the cycle after it is accepted.
// A byte can be taken every cycle; the parser state updates in the accept cycle.
// The single result register sets the rate: req_ready is low only while a result
// waits and rsp_ready is low.
// Synchronous active-high reset clears the parser, the counters and rsp_valid.
module gnss_binary_frame_receiver_core
   import gbfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_res,
   output logic [7:0]  rsp_data_byte,
   output logic [7:0]  rsp_msg_class,
   output logic [7:0]  rsp_msg_id,
   output logic [15:0] rsp_frame_length,
   output logic [15:0] rsp_byte_offset,
   output logic [1:0]  rsp_frame_status,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_SYNC2   = 4'd1,
      PH_CLASS   = 4'd2,
      PH_ID      = 4'd3,
      PH_LEN_LO  = 4'd4,
      PH_LEN_HI  = 4'd5,
      PH_PAYLOAD = 4'd6,
      PH_CK_A    = 4'd7,
      PH_CK_B    = 4'd8,
      PH_TEXT    = 4'd9
   } phase_type;

   // configuration
   logic [15:0] max_payload_ff;
   logic [8:0]  line_max_ff;

   // parser state
   phase_type   phase_ff, phase_in;
   logic [7:0]  class_ff, class_in;
   logic [7:0]  id_ff, id_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] pidx_ff, pidx_in;
   logic [7:0]  sum_a_ff, sum_a_in;
   logic [7:0]  sum_b_ff, sum_b_in;
   logic        too_long_ff, too_long_in;
   logic [8:0]  text_cnt_ff, text_cnt_in;

   // result register
   logic        rsp_valid_ff;
   event_type   event_ff, event_in;
   logic [7:0]  data_ff, data_in;
   logic [15:0] offset_ff, offset_in;
   status_type  status_ff, status_in;

   logic        accept;
   logic [7:0]  c;
   logic [7:0]  fl_a;
   logic [7:0]  fl_b;
   logic [8:0]  line_size;
   logic [8:0]  line_limit;
   logic [15:0] len_full;
   logic [15:0] pidx_next;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign c         = req_rx_byte;

   // running Fletcher sums with this byte folded in
   assign fl_a = sum_a_ff + c;
   assign fl_b = sum_b_ff + fl_a;

   always_comb begin
      line_size = line_max_ff;
      if (line_max_ff < LINE_SIZE_MIN) line_size = LINE_SIZE_MIN;
      if (line_max_ff > LINE_SIZE_MAX) line_size = LINE_SIZE_MAX;
   end
   assign line_limit = line_size - 9'd1;
   assign len_full   = {c, length_ff[7:0]};
   assign pidx_next  = pidx_ff + 16'd1;

   always_comb begin
      phase_in    = phase_ff;
      class_in    = class_ff;
      id_in       = id_ff;
      length_in   = length_ff;
      pidx_in     = pidx_ff;
      sum_a_in    = sum_a_ff;
      sum_b_in    = sum_b_ff;
      too_long_in = too_long_ff;
      text_cnt_in = text_cnt_ff;
      event_in    = EV_NONE;
      data_in     = 8'd0;
      offset_in   = 16'd0;
      status_in   = ST_GOOD;
      case (phase_ff)
         PH_SYNC2: begin
            phase_in = (c == SYNC_TWO) ? PH_CLASS : PH_IDLE;
         end
         PH_CLASS: begin
            class_in = c;
            sum_a_in = c;
            sum_b_in = c;
            phase_in = PH_ID;
         end
         PH_ID: begin
            id_in    = c;
            sum_a_in = fl_a;
            sum_b_in = fl_b;
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            length_in = {8'd0, c};
            sum_a_in  = fl_a;
            sum_b_in  = fl_b;
            phase_in  = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            length_in   = len_full;
            sum_a_in    = fl_a;
            sum_b_in    = fl_b;
            pidx_in     = 16'd0;
            too_long_in = (len_full > max_payload_ff);
            phase_in    = (len_full != 16'd0) ? PH_PAYLOAD : PH_CK_A;
         end
         PH_PAYLOAD: begin
            sum_a_in = fl_a;
            sum_b_in = fl_b;
            if (!too_long_ff) begin
               event_in  = EV_PAYLOAD;
               data_in   = c;
               offset_in = pidx_ff;
            end
            pidx_in = pidx_next;
            // offset wrap also closes the payload
            if (pidx_next == 16'd0 || pidx_next >= length_ff) phase_in = PH_CK_A;
         end
         PH_CK_A: begin
            if (c == sum_a_ff) begin
               phase_in = PH_CK_B;
            end else begin
               event_in  = EV_FRAME_END;
               status_in = too_long_ff ? ST_TOO_LONG : ST_CKSUM;
               phase_in  = PH_IDLE;
            end
         end
         PH_CK_B: begin
            event_in  = EV_FRAME_END;
            status_in = too_long_ff ? ST_TOO_LONG :
                        ((c == sum_b_ff) ? ST_GOOD : ST_CKSUM);
            phase_in  = PH_IDLE;
         end
         PH_TEXT: begin
            if (c == TEXT_LF) begin
               event_in  = EV_LINE_END;
               offset_in = {7'd0, text_cnt_ff};
               phase_in  = PH_IDLE;
            end else if (c == TEXT_CR) begin
               phase_in = PH_TEXT;
            end else if (text_cnt_ff < line_limit) begin
               event_in    = EV_TEXT_CHAR;
               data_in     = c;
               offset_in   = {7'd0, text_cnt_ff};
               text_cnt_in = text_cnt_ff + 9'd1;
            end else begin
               event_in = EV_LINE_DROP;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            // idle, and any stray phase code
            phase_in = PH_IDLE;
            if (c == SYNC_ONE) begin
               phase_in = PH_SYNC2;
            end else if (c == TEXT_START) begin
               phase_in    = PH_TEXT;
               event_in    = EV_TEXT_CHAR;
               data_in     = c;
               text_cnt_in = 9'd1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RST;
         line_max_ff    <= NMEA_LINE_MAX_RST;
      end else if (csr_we) begin
         if (csr_index == CSR_MAX_PAYLOAD)   max_payload_ff <= csr_wdata;
         if (csr_index == CSR_NMEA_LINE_MAX) line_max_ff    <= csr_wdata[8:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         class_ff     <= 8'd0;
         id_ff        <= 8'd0;
         length_ff    <= 16'd0;
         pidx_ff      <= 16'd0;
         sum_a_ff     <= 8'd0;
         sum_b_ff     <= 8'd0;
         too_long_ff  <= 1'b0;
         text_cnt_ff  <= 9'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff    <= phase_in;
            class_ff    <= class_in;
            id_ff       <= id_in;
            length_ff   <= length_in;
            pidx_ff     <= pidx_in;
            sum_a_ff    <= sum_a_in;
            sum_b_ff    <= sum_b_in;
            too_long_ff <= too_long_in;
            text_cnt_ff <= text_cnt_in;
         end
         if (accept) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         event_ff  <= event_in;
         data_ff   <= data_in;
         offset_ff <= offset_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_res    = event_ff;
   assign rsp_data_byte    = data_ff;
   assign rsp_msg_class    = class_ff;
   assign rsp_msg_id       = id_ff;
   assign rsp_frame_length = length_ff;
   assign rsp_byte_offset  = offset_ff;
   assign rsp_frame_status = status_ff;

   // every accepted byte leaves a result behind
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   // status is only nonzero on a frame end
   a_status_only_on_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && event_ff != EV_FRAME_END) |-> status_ff == ST_GOOD)
      else $error("frame status outside a frame end");

   // data only carried by payload and text character events
   a_data_only_on_bytes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && event_ff != EV_PAYLOAD && event_ff != EV_TEXT_CHAR)
      |-> data_ff == 8'd0)
      else $error("data byte set on a non-data event");

   // the line counter can never pass the largest line limit
   a_text_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      text_cnt_ff <= LINE_SIZE_MAX - 9'd1)
      else $error("text counter overran");

   // no payload streamed for a frame flagged too long
   a_no_payload_too_long: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_PAYLOAD && too_long_ff) |=> event_ff == EV_NONE)
      else $error("payload streamed for oversize frame");

endmodule
